FILE: rtl/rpgs_pkg.sv
`default_nettype none

package rpgs_pkg;

	// Field widths of the item, result and configuration channels.
	localparam int MODE_W   = 2;
	localparam int CODE_W   = 11;
	localparam int LOGIT_W  = 24;
	localparam int FRAME_W  = 13;
	localparam int PEN_W    = 14;
	localparam int INV_W    = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// Penalised values are Q.8 and saturate to 26 bits.
	localparam int VAL_W   = 26;
	localparam int FRAC_SHIFT = 12;
	localparam int PROD_W  = LOGIT_W + PEN_W + 1;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2048);
	localparam logic signed [PROD_W-1:0] VAL_MAX_P  = PROD_W'(33554431);
	localparam logic signed [PROD_W-1:0] VAL_MIN_P  = -PROD_W'(33554432);
	localparam logic signed [VAL_W-1:0]  VAL_MIN    = {1'b1, {(VAL_W-1){1'b0}}};

	// End-of-sequence may only end the job once this many frames are out.
	localparam logic [FRAME_W-1:0] EOS_MIN_FRAMES = FRAME_W'(2);

	// Configuration reset values.
	localparam logic [FRAME_W-1:0] MAX_FRAMES_RST  = FRAME_W'(4096);
	localparam logic [PEN_W-1:0]   PENALTY_RST     = PEN_W'(4710);
	localparam logic [INV_W-1:0]   INV_PENALTY_RST = INV_W'(3562);

	// Seen-code memory entries hold an epoch mark; zero never matches.
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
	localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;

	typedef enum logic [MODE_W-1:0] {
		MODE_START = 2'd0,
		MODE_CODE  = 2'd1,
		MODE_EOS   = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_FRAMES  = 2'd0,
		CFG_PENALTY     = 2'd1,
		CFG_INV_PENALTY = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

	// A write to the seen memory, kept for forwarding to later reads.
	typedef struct packed {
		logic               valid;
		logic [CODE_W-1:0]  code;
		logic [EPOCH_W-1:0] epoch;
	} seen_wr_t;

endpackage

`default_nettype wire

FILE: rtl/rpgs_item_if.sv
`default_nettype none

interface rpgs_item_if;
	logic                                valid;
	logic                                ready;
	logic [rpgs_pkg::MODE_W-1:0]         mode;
	logic [rpgs_pkg::CODE_W-1:0]         code_index;
	logic signed [rpgs_pkg::LOGIT_W-1:0] logit;

	modport source (output valid, mode, code_index, logit, input ready);
	modport sink (input valid, mode, code_index, logit, output ready);
endinterface

`default_nettype wire

FILE: rtl/rpgs_result_if.sv
`default_nettype none

interface rpgs_result_if;
	logic                         valid;
	logic                         ready;
	logic [rpgs_pkg::CODE_W-1:0]  chosen_code;
	logic [rpgs_pkg::FRAME_W-1:0] frame_index;
	logic                         code_valid;
	logic                         stopped_by_eos;
	logic                         last;

	modport source (output valid, chosen_code, frame_index, code_valid, stopped_by_eos, last,
		input ready);
	modport sink (input valid, chosen_code, frame_index, code_valid, stopped_by_eos, last,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/rpgs_cfg_if.sv
`default_nettype none

interface rpgs_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rpgs_pkg::CFG_IDX_W-1:0]    index;
	logic [rpgs_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/rpgs_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written returns the old contents.
module rpgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/repetition_penalty_greedy_sampler.sv
`default_nettype none

// Greedy code sampler with a repetition penalty.
// Item channel: a start transaction opens a job; then each frame streams one code
// transaction per candidate code and closes with an end-of-sequence transaction.
// Result channel: one transaction per closing item while a job runs, carrying the
// chosen code and frame number, or the end-of-sequence stop; last marks the end of
// the job. Configuration channel: always ready; the user must write it only while the
// block is idle, which the block does not enforce. Throughput is one item per cycle
// unless the pipeline holds or a clearing pass runs. Results are registered after
// stage 2. The stages are the seen-memory read, the penalty multiply, then rounding,
// saturation and the running maximum. The seen codes live in one RAM of VOCAB_SIZE
// epoch marks, so a start needs no clear. After reset, and after every 255th start, a
// clearing pass writes the whole RAM, one entry a cycle, with item.ready low.
// While the receiver stalls, the item channel keeps flowing until a second result
// would be produced, and then the pipeline holds.
module repetition_penalty_greedy_sampler #(
	parameter int VOCAB_SIZE = 2048
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rpgs_item_if.sink  item,
	rpgs_result_if.source result,
	rpgs_cfg_if.sink   cfg
);

	localparam int AW = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(VOCAB_SIZE - 1);

	// Configuration registers.
	logic [rpgs_pkg::FRAME_W-1:0] max_frames_q;
	logic [rpgs_pkg::PEN_W-1:0]   penalty_q;
	logic [rpgs_pkg::INV_W-1:0]   inv_penalty_q;

	// Job state.
	logic signed [rpgs_pkg::VAL_W-1:0] best_q;
	logic [rpgs_pkg::CODE_W-1:0]       best_code_q;
	logic                              cand_q;
	logic [rpgs_pkg::FRAME_W-1:0]      frame_q;
	logic                              finished_q;

	// Epoch marks and the clearing pass.
	logic [rpgs_pkg::EPOCH_W-1:0] epoch_q;
	logic                         sweep_q;
	logic                         sweep_pend_q;
	logic [AW-1:0]                sweep_addr_q;

	// Stage 1: seen-memory read data arrives, multiply.
	logic                                s1_v_s1;
	rpgs_pkg::mode_t                     mode_s1;
	logic [rpgs_pkg::CODE_W-1:0]         code_s1;
	logic signed [rpgs_pkg::LOGIT_W-1:0] logit_s1;
	logic [rpgs_pkg::EPOCH_W-1:0]        epoch_s1;

	// Stage 2: round, saturate, compare, close the frame.
	logic                                s2_v_s2;
	rpgs_pkg::mode_t                     mode_s2;
	logic [rpgs_pkg::CODE_W-1:0]         code_s2;
	logic signed [rpgs_pkg::LOGIT_W-1:0] logit_s2;
	logic [rpgs_pkg::EPOCH_W-1:0]        epoch_s2;
	logic                                seen_s2;
	logic signed [rpgs_pkg::PROD_W-1:0]  prod_s2;

	// Output register.
	logic                         out_v_q;
	logic [rpgs_pkg::CODE_W-1:0]  out_code_q;
	logic [rpgs_pkg::FRAME_W-1:0] out_frame_q;
	logic                         out_code_valid_q;
	logic                         out_eos_q;
	logic                         out_last_q;

	rpgs_pkg::seen_wr_t wr_q;
	rpgs_pkg::seen_wr_t wr_now;

	logic [rpgs_pkg::EPOCH_W-1:0] ram_rdata;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [rpgs_pkg::EPOCH_W-1:0] ram_wdata;

	logic en;
	logic accept;
	logic res_pending;

	// Stage 1 logic.
	logic [rpgs_pkg::PEN_W-1:0]         factor;
	logic signed [rpgs_pkg::PROD_W-1:0] mul_a;
	logic signed [rpgs_pkg::PROD_W-1:0] mul_b;
	logic                               seen_s1;

	// Stage 2 logic.
	logic signed [rpgs_pkg::PROD_W-1:0] rounded;
	logic signed [rpgs_pkg::VAL_W-1:0]  pen_val;
	logic signed [rpgs_pkg::VAL_W-1:0]  value;
	logic signed [rpgs_pkg::VAL_W-1:0]  eos_val;
	logic                               code_ok;
	logic                               take;
	logic                               eos_stop;
	logic [rpgs_pkg::FRAME_W-1:0]       frame_next;

	// The pipeline only holds when stage 2 has a result and the output register
	// is still full. Nothing else stops it.
	assign res_pending = s2_v_s2 && (mode_s2 == rpgs_pkg::MODE_EOS) && !finished_q;
	assign en          = !(res_pending && out_v_q && !result.ready);
	assign item.ready  = en && !sweep_q && !sweep_pend_q;
	assign accept      = item.valid && item.ready;
	assign cfg.ready   = 1'b1;

	// Stage 1: the factor depends only on the sign, so the product is formed for
	// every item and the seen flag selects it in stage 2.
	assign factor = logit_s1[rpgs_pkg::LOGIT_W-1] ? penalty_q
		: rpgs_pkg::PEN_W'(inv_penalty_q);
	assign mul_a  = rpgs_pkg::PROD_W'(logit_s1);
	assign mul_b  = rpgs_pkg::PROD_W'($signed({1'b0, factor}));

	// The RAM read was issued when the item was accepted. A write at that same
	// edge is caught through wr_q, and the write at the edge that moves this item
	// on is caught through wr_now. Writes of an older job carry another epoch.
	always_comb begin
		seen_s1 = (ram_rdata == epoch_s1);
		if (wr_q.valid && wr_q.code == code_s1 && wr_q.epoch == epoch_s1) begin
			seen_s1 = 1'b1;
		end
		if (wr_now.valid && wr_now.code == code_s1 && wr_now.epoch == epoch_s1) begin
			seen_s1 = 1'b1;
		end
	end

	// Stage 2: round half up on Q.12 and saturate to the 26-bit range.
	assign rounded = (prod_s2 + rpgs_pkg::ROUND_HALF) >>> rpgs_pkg::FRAC_SHIFT;

	always_comb begin
		if (rounded > rpgs_pkg::VAL_MAX_P) begin
			pen_val = rpgs_pkg::VAL_W'(rpgs_pkg::VAL_MAX_P);
		end else if (rounded < rpgs_pkg::VAL_MIN_P) begin
			pen_val = rpgs_pkg::VAL_MIN;
		end else begin
			pen_val = rpgs_pkg::VAL_W'(rounded);
		end
	end

	assign eos_val    = rpgs_pkg::VAL_W'(logit_s2);
	assign value      = seen_s2 ? pen_val : eos_val;
	assign code_ok    = int'(code_s2) < VOCAB_SIZE;
	assign take       = !cand_q || (value > best_q);
	assign eos_stop   = (frame_q >= rpgs_pkg::EOS_MIN_FRAMES) && (eos_val > best_q);
	assign frame_next = frame_q + rpgs_pkg::FRAME_W'(1);

	// A frame that closes with a code marks that code seen in this job's epoch.
	always_comb begin
		wr_now.valid = en && res_pending && !eos_stop;
		wr_now.code  = best_code_q;
		wr_now.epoch = epoch_s2;
	end

	// The clearing pass and frame closes never overlap: the pass starts only
	// once the pipeline has drained.
	always_comb begin
		if (sweep_q) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_addr_q;
			ram_wdata = rpgs_pkg::EPOCH_CLEAR;
		end else begin
			ram_we    = wr_now.valid;
			ram_waddr = AW'(wr_now.code);
			ram_wdata = wr_now.epoch;
		end
	end

	rpgs_ram #(
		.WIDTH(rpgs_pkg::EPOCH_W),
		.DEPTH(VOCAB_SIZE)
	) u_seen_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(AW'(item.code_index)),
		.rdata(ram_rdata)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frames_q  <= rpgs_pkg::MAX_FRAMES_RST;
			penalty_q     <= rpgs_pkg::PENALTY_RST;
			inv_penalty_q <= rpgs_pkg::INV_PENALTY_RST;
		end else if (cfg.valid) begin
			case (rpgs_pkg::cfg_idx_t'(cfg.index))
				rpgs_pkg::CFG_MAX_FRAMES: begin
					max_frames_q <= rpgs_pkg::FRAME_W'(cfg.data);
				end
				rpgs_pkg::CFG_PENALTY: begin
					penalty_q <= rpgs_pkg::PEN_W'(cfg.data);
				end
				rpgs_pkg::CFG_INV_PENALTY: begin
					inv_penalty_q <= rpgs_pkg::INV_W'(cfg.data);
				end
				default: begin
				end
			endcase
		end
	end

	// Epochs move on when a start is accepted, so every later item compares
	// against the new job's mark. When the mark wraps, a clearing pass follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q      <= rpgs_pkg::EPOCH_FIRST;
			sweep_q      <= 1'b1;
			sweep_pend_q <= 1'b0;
			sweep_addr_q <= '0;
		end else begin
			if (accept && item.mode == rpgs_pkg::MODE_START) begin
				if (epoch_q == rpgs_pkg::EPOCH_LAST) begin
					epoch_q      <= rpgs_pkg::EPOCH_FIRST;
					sweep_pend_q <= 1'b1;
				end else begin
					epoch_q <= epoch_q + rpgs_pkg::EPOCH_W'(1);
				end
			end
			if (sweep_pend_q && !s1_v_s1 && !s2_v_s2) begin
				sweep_pend_q <= 1'b0;
				sweep_q      <= 1'b1;
				sweep_addr_q <= '0;
			end
			if (sweep_q) begin
				sweep_addr_q <= sweep_addr_q + AW'(1);
				if (sweep_addr_q == LAST_ADDR) begin
					sweep_q <= 1'b0;
				end
			end
		end
	end

	// Pipeline valid bits and the forwarding record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
			s2_v_s2 <= 1'b0;
			wr_q    <= '0;
		end else if (en) begin
			s1_v_s1 <= accept;
			s2_v_s2 <= s1_v_s1;
			wr_q    <= wr_now;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en) begin
			if (accept) begin
				mode_s1  <= rpgs_pkg::mode_t'(item.mode);
				code_s1  <= item.code_index;
				logit_s1 <= item.logit;
				epoch_s1 <= epoch_q;
			end
			mode_s2  <= mode_s1;
			code_s2  <= code_s1;
			logit_s2 <= logit_s1;
			epoch_s2 <= epoch_s1;
			seen_s2  <= seen_s1;
			prod_s2  <= mul_a * mul_b;
		end
	end

	// Running maximum, frame count and job state, updated in item order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= rpgs_pkg::VAL_MIN;
			best_code_q <= '0;
			cand_q      <= 1'b0;
			frame_q     <= '0;
			finished_q  <= 1'b1;
		end else if (en && s2_v_s2) begin
			if (mode_s2 == rpgs_pkg::MODE_START) begin
				best_q      <= rpgs_pkg::VAL_MIN;
				best_code_q <= '0;
				cand_q      <= 1'b0;
				frame_q     <= '0;
				finished_q  <= 1'b0;
			end else if (!finished_q) begin
				case (mode_s2)
					rpgs_pkg::MODE_CODE: begin
						if (code_ok && take) begin
							best_q      <= value;
							best_code_q <= code_s2;
							cand_q      <= 1'b1;
						end
					end
					rpgs_pkg::MODE_EOS: begin
						best_q      <= rpgs_pkg::VAL_MIN;
						best_code_q <= '0;
						cand_q      <= 1'b0;
						if (eos_stop) begin
							finished_q <= 1'b1;
						end else begin
							frame_q <= frame_next;
							if (frame_next >= max_frames_q) begin
								finished_q <= 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Output register: loaded when a frame closes, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en && res_pending) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_pending) begin
			if (eos_stop) begin
				out_code_q       <= '0;
				out_frame_q      <= frame_q;
				out_code_valid_q <= 1'b0;
				out_eos_q        <= 1'b1;
				out_last_q       <= 1'b1;
			end else begin
				out_code_q       <= best_code_q;
				out_frame_q      <= frame_next;
				out_code_valid_q <= 1'b1;
				out_eos_q        <= 1'b0;
				out_last_q       <= (frame_next >= max_frames_q);
			end
		end
	end

	assign result.valid          = out_v_q;
	assign result.chosen_code    = out_code_q;
	assign result.frame_index    = out_frame_q;
	assign result.code_valid     = out_code_valid_q;
	assign result.stopped_by_eos = out_eos_q;
	assign result.last           = out_last_q;

endmodule

`default_nettype wire
